// ===== src/urs_pkg.sv =====
// Shared types and constants for the unbiased range sampler.
package urs_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned IdxW  = 8;

  localparam logic [IdxW-1:0] RegBoundLow  = 8'd0;
  localparam logic [IdxW-1:0] RegBoundHigh = 8'd1;

  localparam logic [WordW-1:0] AllOnes = {WordW{1'b1}};

  // Derived interval settings handed from the config unit to the datapath.
  typedef struct packed {
    logic [WordW-1:0] low;
    logic [WordW-1:0] span;
    logic [WordW-1:0] limit;
    logic             degen;
    logic             full;
    logic             busy;
  } cfg_t;

endpackage

// ===== src/urs_config.sv =====
// Bound registers and the serial divider that derives the rejection limit.
module urs_config
  import urs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [63:0]     cfg_data,
  output cfg_t            cfg
);

  logic [63:0] bound_low;
  logic [63:0] bound_high;
  logic [63:0] span;
  logic [63:0] rem;
  logic [63:0] limit;
  logic [5:0]  cnt;
  logic        start;
  logic        run;
  logic [64:0] trial;
  logic [64:0] diff;

  always_comb begin
    trial = {rem, 1'b1};
    diff  = trial - {1'b0, span};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_low  <= '0;
      bound_high <= '0;
      start      <= 1'b0;
      run        <= 1'b0;
      cnt        <= '0;
    end else begin
      start <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == RegBoundLow) begin
          bound_low <= cfg_data;
        end else if (cfg_index == RegBoundHigh) begin
          bound_high <= cfg_data;
        end
        start <= 1'b1;
        run   <= 1'b0;
      end else if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run <= 1'b0;
        end
      end
    end
  end

  // Remainder of all-ones by span, one bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      span <= bound_high - bound_low + 64'd1;
      rem  <= '0;
    end else if (run) begin
      if (!diff[64]) begin
        rem <= diff[63:0];
      end else begin
        rem <= trial[63:0];
      end
      if (cnt == 6'd63) begin
        limit <= AllOnes - (diff[64] ? trial[63:0] : diff[63:0]);
      end
    end
  end

  always_comb begin
    cfg.low   = bound_low;
    cfg.span  = span;
    cfg.limit = limit;
    cfg.degen = ($signed(bound_low) >= $signed(bound_high));
    cfg.full  = (span == '0);
    cfg.busy  = start | run | cfg_valid;
  end

endmodule

// ===== src/unbiased_range_sampler_unit.sv =====
// Top level of the unbiased range sampler.
//
// Input channel in_valid/in_ready carries random_word; output channel
// out_valid/out_ready carries accepted and sample. Every transferred word
// produces exactly one result, in order.
// Config channel cfg_valid/cfg_ready writes bound_low (index 0) and
// bound_high (index 1); other indexes are ignored. cfg_ready is always high.
// After any config write, a serial divider computes the rejection limit;
// in_ready stays low meanwhile.
// The pipeline has one entry stage, 64 restoring remainder stages (one
// quotient bit each), and one output stage that adds bound_low.
// Throughput is one word per cycle. A stall on out_ready freezes the whole
// pipeline and drops in_ready; nothing is lost or repeated.
// Reset clears both bounds to zero (single-point interval, every result
// accepted with sample 0) and empties the pipeline.
module unbiased_range_sampler_unit
  import urs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [63:0]     random_word,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            accepted,
  output logic [63:0]     sample,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [63:0]     cfg_data
);

  localparam int unsigned Steps = 64;

  cfg_t        cfg;
  logic        adv;
  logic        v   [0:Steps];
  logic        rej [0:Steps];
  logic [63:0] rem [0:Steps];
  logic [63:0] wrd [0:Steps];

  urs_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv && !cfg.busy;

  // Entry stage: decide rejection against the limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rej[0] <= !cfg.degen && !cfg.full && (random_word >= cfg.limit);
      rem[0] <= '0;
      wrd[0] <= random_word;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [64:0] trial;
    logic [64:0] diff;

    always_comb begin
      trial = {rem[i], wrd[i][63]};
      diff  = trial - {1'b0, cfg.span};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rej[i+1] <= rej[i];
        rem[i+1] <= diff[64] ? trial[63:0] : diff[63:0];
        wrd[i+1] <= {wrd[i][62:0], 1'b0};
      end
    end
  end

  // Output stage: add bound_low, or force the special cases.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cfg.degen) begin
        accepted <= 1'b1;
        sample   <= cfg.low;
      end else if (rej[Steps]) begin
        accepted <= 1'b0;
        sample   <= '0;
      end else begin
        accepted <= 1'b1;
        sample   <= cfg.low + rem[Steps];
      end
    end
  end

endmodule

// ===== src/urs_checker.sv =====
// Port-level assertions for the unbiased range sampler, bound to the top level.
module urs_checker
  import urs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        accepted,
  input logic [63:0] sample,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(accepted))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> sample == '0)
    else $error("rejected result carries nonzero sample");

  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken while limit is recomputed");

endmodule

bind unbiased_range_sampler_unit urs_checker u_urs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .accepted  (accepted),
  .sample    (sample),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ===== sim/testbench.sv =====
// Testbench for the unbiased range sampler: predicts each result and checks it in order.
module testbench;
  import urs_pkg::*;

  typedef struct packed {
    logic        acc;
    logic [63:0] val;
  } draw_t;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  logic [63:0]     random_word;
  logic            out_valid;
  logic            out_ready;
  logic            accepted;
  logic [63:0]     sample;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [IdxW-1:0] cfg_index;
  logic [63:0]     cfg_data;

  logic [63:0] lo_bound;
  logic [63:0] hi_bound;
  draw_t       draws_pending[$];
  int          errors;
  int          send_idle_pct;
  int          recv_stall_pct;

  unbiased_range_sampler_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .random_word(random_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .sample(sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic draw_t draw_from_word(input logic [63:0] w);
    draw_t       d;
    logic [63:0] span;
    logic [63:0] limit;
    d.acc = 1'b1;
    if ($signed(lo_bound) >= $signed(hi_bound)) begin
      d.val = lo_bound;
      return d;
    end
    span = hi_bound - lo_bound + 64'd1;
    if (span == 64'd0) begin
      d.val = lo_bound + w;
      return d;
    end
    limit = AllOnes - (AllOnes % span);
    if (w >= limit) begin
      d.acc = 1'b0;
      d.val = 64'd0;
    end else begin
      d.val = lo_bound + (w % span);
    end
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Receiver: random stall on out_ready, compare on every transfer.
  always @(posedge clk) begin
    draw_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (draws_pending.size() == 0) begin
          report_mismatch("result with nothing pending");
        end else begin
          e = draws_pending.pop_front();
          if (accepted !== e.acc)
            report_mismatch($sformatf("accepted %b, want %b", accepted, e.acc));
          if (sample !== e.val)
            report_mismatch($sformatf("sample %h, want %h", sample, e.val));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Leave in_valid high after the transfer; an idle in the next send, or a drain, drops it.
  task automatic send_word(input logic [63:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    random_word <= w;
    draws_pending.push_back(draw_from_word(w));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drain, then let the pipeline settle before touching the bounds.
  task automatic drain;
    in_valid <= 1'b0;
    while (draws_pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Leave cfg_valid high after the transfer; the caller drops it.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == RegBoundLow) lo_bound = v;
    else if (idx == RegBoundHigh) hi_bound = v;
  endtask

  task automatic set_bounds(input logic [63:0] lo, input logic [63:0] hi);
    drain();
    write_reg(RegBoundLow, lo);
    write_reg(RegBoundHigh, hi);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // Words near the rejection limit exercise both sides of it.
  function automatic logic [63:0] pick_word;
    logic [63:0] span;
    logic [63:0] limit;
    span = hi_bound - lo_bound + 64'd1;
    if (span != 0 && $urandom_range(3) == 0) begin
      limit = AllOnes - (AllOnes % span);
      return limit + 64'($signed($urandom_range(8)) - 4);
    end
    return rand64();
  endfunction

  task automatic test_reset_state;
    send_word(64'd0);
    send_word(AllOnes);
    send_word(64'h8000_0000_0000_0000);
  endtask

  task automatic test_directed;
    set_bounds(64'd0, 64'd9);
    send_word(64'd0);
    send_word(64'd9);
    send_word(64'd10);
    send_word(AllOnes);
    send_word(AllOnes - 64'd6);
    send_word(AllOnes - 64'd5);
    set_bounds(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(64'd0);
    send_word(AllOnes);
    send_word(64'h1234_5678_9ABC_DEF0);
    set_bounds(64'd5, -64'sd5);
    send_word(64'd77);
    send_word(AllOnes);
    set_bounds(-64'sd3, -64'sd3);
    send_word(64'd1);
    set_bounds(64'h8000_0000_0000_0000, 64'd0);
    send_word(AllOnes);
    send_word(64'h8000_0000_0000_0000);
    send_word(64'h7FFF_FFFF_FFFF_FFFF);
    drain();
    write_reg(8'd2, 64'd123);
    write_reg(AllOnes[IdxW-1:0], 64'd99);
    cfg_valid <= 1'b0;
    send_word(64'd4);
  endtask

  task automatic test_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        k = $urandom_range(5);
        case (k)
          0: set_bounds(rand64(), rand64());
          1: set_bounds(64'($signed($urandom_range(200)) - 100),
                        64'($urandom_range(1000)));
          2: set_bounds(rand64() >> $urandom_range(63), rand64() >> $urandom_range(63));
          3: set_bounds(64'h8000_0000_0000_0000, rand64());
          4: set_bounds(rand64(), 64'h7FFF_FFFF_FFFF_FFFF);
          default: set_bounds(64'd0, (64'd1 << $urandom_range(63)) + 64'd1);
        endcase
        case ((i / 40) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
          default: begin send_idle_pct = 17; recv_stall_pct = 17; end
        endcase
      end
      send_word(pick_word());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    random_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    lo_bound = '0;
    hi_bound = '0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random(1330);
    drain();
    if (errors == 0 && draws_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/urs_pkg.sv
src/urs_config.sv
src/unbiased_range_sampler_unit.sv
src/urs_checker.sv
sim/testbench.sv
